// ===== hw/rtl/bsss_pkg.sv =====
// bsss_pkg: shared widths and defaults for the byte set sort and statistics block
// used by the top level, the port checker and the bench; no dependencies
package bsss_pkg;

   localparam int DEFAULT_MAX_SAMPLES = 32;

   localparam int SAMPLE_W   = 8;
   localparam int SAMPLE_MAX = 255;
   localparam int RANK_W     = 5;
   localparam int SIZE_W     = 6;

   // result word layout, lowest bit up
   localparam int RSP_VALUE_LSB  = 0;
   localparam int RSP_RANK_LSB   = RSP_VALUE_LSB + SAMPLE_W;
   localparam int RSP_MIN_LSB    = RSP_RANK_LSB + RANK_W;
   localparam int RSP_MAX_LSB    = RSP_MIN_LSB + SAMPLE_W;
   localparam int RSP_MEAN_LSB   = RSP_MAX_LSB + SAMPLE_W;
   localparam int RSP_MEDIAN_LSB = RSP_MEAN_LSB + SAMPLE_W;
   localparam int RSP_SIZE_LSB   = RSP_MEDIAN_LSB + SAMPLE_W;
   localparam int RSP_OVF_LSB    = RSP_SIZE_LSB + SIZE_W;
   localparam int RSP_FIELDS_W   = RSP_OVF_LSB + 1;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int REQ_DATA_W = SAMPLE_W;

endpackage

// ===== hw/rtl/bsss_div.sv =====
// bsss_div: restoring divider, one quotient bit per cycle, for the set mean
// standalone; started by the top level sequencer, pulses done when the quotient is ready
module bsss_div #(
   parameter int DIVIDEND_W = 14,
   parameter int DIVISOR_W  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/byte_set_sort_and_statistics.sv =====
// byte_set_sort_and_statistics: collects byte samples, insertion-sorts them in place
// in a one-read one-write store and streams them out largest first with set statistics
// depends on bsss_pkg and bsss_div
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/req_tready  req_tdata = sample, req_tlast = last_sample
//   rsp       out   rsp_tvalid/rsp_tready  rsp_tdata = result fields, rsp_tlast = last_of_run
//
// loading takes one sample per cycle; the block is ready only while loading
// sorting walks the store through its single read port: each key is read and latched,
// each smaller element above the hole shifts down a place, then the key is written
// statistics read the minimum, the maximum and the middle elements, then run the mean divider
// each result is read, then registered once the output is free; a stalled result holds
// the run state clears when the final result is registered, so the next set loads
// while it waits; synchronous reset clears the state, count, drop flag, sum and output valid
module byte_set_sort_and_statistics #(
   parameter int MAX_SAMPLES = bsss_pkg::DEFAULT_MAX_SAMPLES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bsss_pkg::REQ_DATA_W-1:0]     req_tdata,   // sample[7:0]
   input  logic                                req_tlast,   // last_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sorted_value[7:0], rank[12:8], set_minimum[20:13], set_maximum[28:21],
   // set_mean[36:29], set_median[44:37], set_size[50:45], overflowed[51], zero[55:52]
   output logic [bsss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast    // last_of_run
);

   import bsss_pkg::*;

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = $clog2(MAX_SAMPLES * SAMPLE_MAX + 1);

   localparam logic [3:0] ST_LOAD    = 4'd0;
   localparam logic [3:0] ST_KEY_RD  = 4'd1;
   localparam logic [3:0] ST_KEY     = 4'd2;
   localparam logic [3:0] ST_CMP     = 4'd3;
   localparam logic [3:0] ST_PLACE   = 4'd4;
   localparam logic [3:0] ST_MIN     = 4'd5;
   localparam logic [3:0] ST_MAX     = 4'd6;
   localparam logic [3:0] ST_MED_A   = 4'd7;
   localparam logic [3:0] ST_MED_B   = 4'd8;
   localparam logic [3:0] ST_MED_C   = 4'd9;
   localparam logic [3:0] ST_DIV     = 4'd10;
   localparam logic [3:0] ST_EMIT_RD = 4'd11;
   localparam logic [3:0] ST_EMIT_LD = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                drop_ff, drop_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic [AW-1:0]       a_ff, a_in;
   logic [AW-1:0]       b_ff, b_in;
   logic [AW-1:0]       k_ff, k_in;
   logic [SAMPLE_W-1:0] key_ff, key_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] meda_ff, meda_in;
   logic [SAMPLE_W-1:0] median_ff, median_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [SAMPLE_W-1:0] sample_store [MAX_SAMPLES];
   logic [SAMPLE_W-1:0] rdata_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   logic [SAMPLE_W-1:0] mem_wdata;

   logic                div_start;
   logic                div_done;
   logic [SW-1:0]       div_quotient;

   logic                req_fire;
   logic [CW-1:0]       count_next;
   logic [AW-1:0]       half;
   logic                a_is_end;
   logic                k_is_end;
   logic [SAMPLE_W:0]   mid_sum;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign count_next = (count_ff < CW'(MAX_SAMPLES)) ? count_ff + CW'(1) : count_ff;
   assign half       = AW'(count_ff >> 1);
   assign a_is_end   = (CW'(a_ff) + CW'(1)) == count_ff;
   assign k_is_end   = (CW'(k_ff) + CW'(1)) == count_ff;
   assign mid_sum    = {1'b0, meda_ff} + {1'b0, rdata_ff};

   bsss_div #(
      .DIVIDEND_W (SW),
      .DIVISOR_W  (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      sum_in       = sum_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      key_in       = key_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      meda_in      = meda_ff;
      median_in    = median_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = req_tdata[SAMPLE_W-1:0];
      mem_raddr    = a_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_SAMPLES)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
                  sum_in   = sum_ff + SW'(req_tdata[SAMPLE_W-1:0]);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  a_in = AW'(1);
                  if (count_next == CW'(1)) begin
                     state_in = ST_MIN;
                  end else begin
                     state_in = ST_KEY_RD;
                  end
               end
            end
         end
         ST_KEY_RD: begin
            mem_raddr = a_ff;
            state_in  = ST_KEY;
         end
         ST_KEY: begin
            key_in    = rdata_ff;
            b_in      = a_ff;
            mem_raddr = a_ff - AW'(1);
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            // rdata holds the element just above the hole at b
            mem_we    = 1'b1;
            mem_waddr = b_ff;
            mem_raddr = b_ff - AW'(2);
            if (rdata_ff < key_ff) begin
               mem_wdata = rdata_ff;
               b_in      = b_ff - AW'(1);
               if (b_ff == AW'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               mem_wdata = key_ff;
               a_in      = a_ff + AW'(1);
               state_in  = a_is_end ? ST_MIN : ST_KEY_RD;
            end
         end
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = key_ff;
            a_in      = a_ff + AW'(1);
            state_in  = a_is_end ? ST_MIN : ST_KEY_RD;
         end
         ST_MIN: begin
            mem_raddr = AW'(count_ff - CW'(1));
            state_in  = ST_MAX;
         end
         ST_MAX: begin
            min_in    = rdata_ff;
            mem_raddr = '0;
            state_in  = ST_MED_A;
         end
         ST_MED_A: begin
            max_in    = rdata_ff;
            mem_raddr = half;
            state_in  = ST_MED_B;
         end
         ST_MED_B: begin
            meda_in   = rdata_ff;
            mem_raddr = half - AW'(1);
            state_in  = ST_MED_C;
         end
         ST_MED_C: begin
            // odd count: the middle element; even: floor average of the two middles
            if (count_ff[0]) begin
               median_in = meda_ff;
            end else begin
               median_in = mid_sum[SAMPLE_W:1];
            end
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in  = div_quotient[SAMPLE_W-1:0];
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            mem_raddr = k_ff;
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            mem_raddr = k_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = k_is_end;
               rsp_data_in  = '0;
               rsp_data_in[RSP_VALUE_LSB +: SAMPLE_W]  = rdata_ff;
               rsp_data_in[RSP_RANK_LSB +: RANK_W]     = RANK_W'(k_ff);
               rsp_data_in[RSP_MIN_LSB +: SAMPLE_W]    = min_ff;
               rsp_data_in[RSP_MAX_LSB +: SAMPLE_W]    = max_ff;
               rsp_data_in[RSP_MEAN_LSB +: SAMPLE_W]   = mean_ff;
               rsp_data_in[RSP_MEDIAN_LSB +: SAMPLE_W] = median_ff;
               rsp_data_in[RSP_SIZE_LSB +: SIZE_W]     = SIZE_W'(count_ff);
               rsp_data_in[RSP_OVF_LSB]                = drop_ff;
               if (k_is_end) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  sum_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_store[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= sample_store[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      key_ff      <= key_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      meda_ff     <= meda_in;
      median_ff   <= median_in;
      mean_ff     <= mean_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/bsss_checker.sv =====
// bsss_checker: port-level assertions for byte_set_sort_and_statistics, bound to the top
// depends on bsss_pkg for the result word layout
module bsss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bsss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   import bsss_pkg::*;

   logic [SAMPLE_W-1:0] value;
   logic [RANK_W-1:0]   rank;
   logic [SAMPLE_W-1:0] set_min;
   logic [SAMPLE_W-1:0] set_max;
   logic [SIZE_W-1:0]   set_size;

   assign value    = rsp_tdata[RSP_VALUE_LSB +: SAMPLE_W];
   assign rank     = rsp_tdata[RSP_RANK_LSB +: RANK_W];
   assign set_min  = rsp_tdata[RSP_MIN_LSB +: SAMPLE_W];
   assign set_max  = rsp_tdata[RSP_MAX_LSB +: SAMPLE_W];
   assign set_size = rsp_tdata[RSP_SIZE_LSB +: SIZE_W];

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // no new samples are taken until the final word of a run is registered
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input ready in the middle of a run");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (set_min <= value) && (value <= set_max))
      else $error("sorted value outside min and max");

   // next word of the run follows in rank and does not grow
   a_descending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         !rsp_tvalid || ((rank == RANK_W'($past(rank) + RANK_W'(1))) && (value <= $past(value))))
      else $error("run out of order");

   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rank == RANK_W'(set_size - SIZE_W'(1)))
      else $error("final word rank does not match set size");

endmodule

bind byte_set_sort_and_statistics bsss_checker u_bsss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/byte_set_sort_and_statistics_tb.sv =====
// byte_set_sort_and_statistics_tb: self-checking bench for the byte set sorter
// drives sample words over req, checks ranked words and set statistics on rsp
// depends on bsss_pkg and the byte_set_sort_and_statistics rtl
module byte_set_sort_and_statistics_tb;
   import bsss_pkg::*;

   localparam int CAPACITY       = DEFAULT_MAX_SAMPLES;
   localparam int RANDOM_ITEMS   = 400;
   localparam int HOLD_CYCLES    = 800;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int DIRECTED_COUNT = 22;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sorted_value;
      logic [RANK_W-1:0]   rank;
      logic                last_of_run;
      logic [SAMPLE_W-1:0] set_minimum;
      logic [SAMPLE_W-1:0] set_maximum;
      logic [SAMPLE_W-1:0] set_mean;
      logic [SAMPLE_W-1:0] set_median;
      logic [SIZE_W-1:0]   set_size;
      logic                overflowed;
   } sorted_result_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_sample;
      logic                fixed;        // want holds the single word of a one-sample set
      sorted_result_type   want;
   } stim_row_type;

   localparam sorted_result_type NO_RESULT = '0;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // one-sample sets straight after reset, all statistics equal the sample
      {8'h00, 1'b1, 1'b1, {8'h00, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 6'd1, 1'b0}},
      {8'hFF, 1'b1, 1'b1, {8'hFF, 5'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd1, 1'b0}},
      // extremes together, even count
      {8'h00, 1'b0, 1'b0, NO_RESULT},
      {8'hFF, 1'b1, 1'b0, NO_RESULT},
      // all equal
      {8'h80, 1'b0, 1'b0, NO_RESULT},
      {8'h80, 1'b0, 1'b0, NO_RESULT},
      {8'h80, 1'b1, 1'b0, NO_RESULT},
      // ascending arrival, odd count
      {8'h01, 1'b0, 1'b0, NO_RESULT},
      {8'h02, 1'b0, 1'b0, NO_RESULT},
      {8'h03, 1'b0, 1'b0, NO_RESULT},
      {8'h04, 1'b0, 1'b0, NO_RESULT},
      {8'h05, 1'b1, 1'b0, NO_RESULT},
      // duplicates mixed in, even count
      {8'h09, 1'b0, 1'b0, NO_RESULT},
      {8'hC8, 1'b0, 1'b0, NO_RESULT},
      {8'h09, 1'b0, 1'b0, NO_RESULT},
      {8'h4D, 1'b1, 1'b0, NO_RESULT},
      // descending arrival
      {8'hFE, 1'b0, 1'b0, NO_RESULT},
      {8'hFD, 1'b0, 1'b0, NO_RESULT},
      {8'h01, 1'b0, 1'b0, NO_RESULT},
      {8'h00, 1'b1, 1'b0, NO_RESULT},
      {8'h55, 1'b1, 1'b1, {8'h55, 5'd0, 1'b1, 8'h55, 8'h55, 8'h55, 8'h55, 6'd1, 1'b0}},
      {8'hAA, 1'b1, 1'b1, {8'hAA, 5'd0, 1'b1, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 6'd1, 1'b0}}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // predictor state: samples kept for the open set and the drop flag
   logic [SAMPLE_W-1:0]   held [$];
   logic                  spilled = 1'b0;
   sorted_result_type     ranked_due [$];

   int                    fault_count = 0;
   int                    sender_idle_pct = 0;
   int                    receiver_stall_pct = 0;
   int                    hold_left = 0;
   int                    quiet_cycles = 0;
   logic                  pressure_armed = 1'b0;
   logic                  pressure_done = 1'b0;

   byte_set_sort_and_statistics #(
      .MAX_SAMPLES(CAPACITY)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // keeps a sample; a closing sample ranks the set and queues one word per element
   function automatic void take_sample(logic [SAMPLE_W-1:0] smp, logic closes_set);
      logic [SAMPLE_W-1:0] ranked [$];
      sorted_result_type   row;
      int                  n;
      int                  b;
      int                  k;
      int                  total;
      int                  mid;
      if (held.size() < CAPACITY) held.push_back(smp);
      else spilled = 1'b1;
      if (!closes_set) return;
      ranked = {};
      total  = 0;
      foreach (held[a]) begin
         b = 0;
         while (b < ranked.size() && ranked[b] >= held[a]) b++;
         ranked.insert(b, held[a]);
         total += held[a];
      end
      n = ranked.size();
      if (n % 2 == 0) mid = (int'(ranked[n/2]) + int'(ranked[n/2 - 1])) / 2;
      else mid = ranked[n/2];
      for (k = 0; k < n; k++) begin
         row.sorted_value = ranked[k];
         row.rank         = RANK_W'(k);
         row.last_of_run  = (k == n - 1);
         row.set_minimum  = ranked[n - 1];
         row.set_maximum  = ranked[0];
         row.set_mean     = SAMPLE_W'(total / n);
         row.set_median   = SAMPLE_W'(mid);
         row.set_size     = SIZE_W'(n);
         row.overflowed   = spilled;
         ranked_due.push_back(row);
      end
      held.delete();
      spilled = 1'b0;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fault_count++;
      end
   endfunction

   // offers one word, returns at the edge where it is taken; valid stays up for the caller
   task automatic send_word(logic [SAMPLE_W-1:0] smp, logic closes_set);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tlast  <= closes_set;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off once the armed set starts draining
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (pressure_armed && !pressure_done && rsp_tvalid) begin
         pressure_done <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      sorted_result_type got;
      sorted_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sorted_value = rsp_tdata[RSP_VALUE_LSB  +: SAMPLE_W];
         got.rank         = rsp_tdata[RSP_RANK_LSB   +: RANK_W];
         got.last_of_run  = rsp_tlast;
         got.set_minimum  = rsp_tdata[RSP_MIN_LSB    +: SAMPLE_W];
         got.set_maximum  = rsp_tdata[RSP_MAX_LSB    +: SAMPLE_W];
         got.set_mean     = rsp_tdata[RSP_MEAN_LSB   +: SAMPLE_W];
         got.set_median   = rsp_tdata[RSP_MEDIAN_LSB +: SAMPLE_W];
         got.set_size     = rsp_tdata[RSP_SIZE_LSB   +: SIZE_W];
         got.overflowed   = rsp_tdata[RSP_OVF_LSB];
         if (ranked_due.size() == 0) begin
            $error("unexpected result word: value %0d rank %0d",
                   got.sorted_value, got.rank);
            fault_count++;
         end else begin
            want = ranked_due.pop_front();
            check_field("sorted_value", want.sorted_value, got.sorted_value);
            check_field("rank",         want.rank,         got.rank);
            check_field("last_of_run",  want.last_of_run,  got.last_of_run);
            check_field("set_minimum",  want.set_minimum,  got.set_minimum);
            check_field("set_maximum",  want.set_maximum,  got.set_maximum);
            check_field("set_mean",     want.set_mean,     got.set_mean);
            check_field("set_median",   want.set_median,   got.set_median);
            check_field("set_size",     want.set_size,     got.set_size);
            check_field("overflowed",   want.overflowed,   got.overflowed);
         end
      end
   end

   // counts cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                  r;
      int                  depth_before;
      int                  items_sent;
      int                  sets_done;
      int                  set_len;
      int                  fill;
      int                  pick;
      int                  k;
      logic [SAMPLE_W-1:0] smp;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIRECTED_COUNT; r++) begin
         send_word(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].last_sample);
         depth_before = ranked_due.size();
         take_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].last_sample);
         if (DIRECTED_ROWS[r].fixed) begin
            while (ranked_due.size() > depth_before) void'(ranked_due.pop_back());
            ranked_due.push_back(DIRECTED_ROWS[r].want);
         end
      end

      // first sets fill the store exactly, overflow it by the closing sample, and by more
      items_sent     = 0;
      sets_done      = 0;
      pressure_armed = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         case (sets_done)
            0: set_len = CAPACITY;
            1: set_len = CAPACITY + 1;
            2: set_len = CAPACITY + 8;
            default: begin
               pick = $urandom_range(99);
               if (pick < 70) set_len = $urandom_range(8, 1);
               else if (pick < 90) set_len = $urandom_range(CAPACITY - 1, 9);
               else set_len = $urandom_range(CAPACITY + 8, CAPACITY);
            end
         endcase
         case (items_sent * 4 / RANDOM_ITEMS)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         fill = $urandom_range(3);
         for (k = 0; k < set_len; k++) begin
            case (fill)
               0: smp = SAMPLE_W'($urandom);
               1: smp = SAMPLE_W'($urandom_range(103, 100));   // many ties
               2: smp = $urandom_range(1) ? 8'hFF : 8'h00;
               default: smp = SAMPLE_W'($urandom_range(15));
            endcase
            send_word(smp, k == set_len - 1);
            take_sample(smp, k == set_len - 1);
         end
         items_sent += set_len;
         sets_done++;
      end
      req_tvalid <= 1'b0;

      while (ranked_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bsss_pkg.sv
hw/rtl/bsss_div.sv
hw/rtl/byte_set_sort_and_statistics.sv
hw/rtl/bsss_checker.sv
tb/byte_set_sort_and_statistics_tb.sv
